@@ rtl/core/wsmp_pkg.sv @@
// wsmp_pkg: shared types and constants for the wsmp frame parser
// no dependencies; used by the channel interfaces and the parser core

package wsmp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VER_W     = 4;
  localparam int unsigned ID_W      = 28;
  localparam int unsigned ID_LEFT_W = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [VER_W-1:0] VERSION_RESET = 4'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_VERSION  = 3'd0,
    PH_ID_FIRST = 3'd1,
    PH_ID_MORE  = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_TRAIL    = 3'd5,
    PH_SKIP     = 3'd6
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_BAD_PREFIX  = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_t;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data;
    logic [ID_W-1:0]     service_id;
    logic [BYTE_W-1:0]   payload_length;
    status_t             status;
    logic                last;
  } result_t;

endpackage

@@ rtl/core/wsmp_frame_if.sv @@
// wsmp_frame_if: valid/ready channel carrying one received frame byte
// depends on wsmp_pkg for field widths

interface wsmp_frame_if
  import wsmp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ rtl/core/wsmp_result_if.sv @@
// wsmp_result_if: valid/ready channel carrying payload bytes and frame verdicts
// depends on wsmp_pkg for field widths

interface wsmp_result_if
  import wsmp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   data;
  logic [ID_W-1:0]     service_id;
  logic [BYTE_W-1:0]   payload_length;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output kind, output data, output service_id,
                  output payload_length, output status, output last, input ready);
  modport sink   (input valid, input kind, input data, input service_id,
                  input payload_length, input status, input last, output ready);
endinterface

@@ rtl/core/wsmp_frame_parser_core.sv @@
// wsmp_frame_parser_core: byte-wise wsmp short-message frame parser
// depends on wsmp_pkg, wsmp_frame_if and wsmp_result_if
// a result is written into the result queue on the byte transfer that causes it
// throughput: one byte per cycle; a frame ending on a payload byte gives two results,
//   drained one per cycle while result_out.ready is high, from a four-entry result queue;
//   input is ready while two queue entries are free
// reset (rst, synchronous): parser waits for a version byte, queue empty, version 3

module wsmp_frame_parser_core
  import wsmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [VER_W-1:0]   cfg_wr_data,
  wsmp_frame_if.sink         frame_in,
  wsmp_result_if.source      result_out
);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W   = PTR_W + 1;

  logic [VER_W-1:0]     exp_version;

  phase_t               phase, phase_next;
  logic [ID_W-1:0]      id_acc, id_acc_next;
  logic [ID_LEFT_W-1:0] id_left, id_left_next;
  logic [BYTE_W-1:0]    decl_len, decl_len_next;
  logic [BYTE_W-1:0]    pay_left, pay_left_next;
  status_t              err_code, err_code_next;

  logic                 pay_valid;
  logic                 verdict_valid;
  result_t              pay_res;
  result_t              verdict_res;
  result_t              first_res;
  logic [PTR_W-1:0]     n_res;

  result_t              q [Q_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  logic                 in_fire;
  logic                 out_fire;
  logic [BYTE_W-1:0]    b;

  assign b        = frame_in.frame_byte;
  assign frame_in.ready = (count <= CNT_W'(Q_DEPTH - 2));
  assign in_fire  = frame_in.valid && frame_in.ready;
  assign out_fire = result_out.valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_version <= VERSION_RESET;
    end else if (cfg_wr_en) begin
      exp_version <= cfg_wr_data;
    end
  end

  // one parse step per byte transfer
  always_comb begin
    phase_next    = phase;
    id_acc_next   = id_acc;
    id_left_next  = id_left;
    decl_len_next = decl_len;
    pay_left_next = pay_left;
    err_code_next = err_code;
    pay_valid     = 1'b0;
    verdict_valid = 1'b0;

    pay_res                = '0;
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.data           = b;
    pay_res.status         = ST_OK;

    case (phase)
      PH_VERSION: begin
        if (b[VER_W-1:0] == exp_version) begin
          phase_next = PH_ID_FIRST;
        end else begin
          err_code_next = ST_BAD_VERSION;
          phase_next    = PH_SKIP;
        end
      end
      PH_ID_FIRST: begin
        if (b[7] == 1'b0) begin
          id_acc_next = ID_W'(b);
          phase_next  = PH_LENGTH;
        end else if (b[7:6] == 2'b10) begin
          id_acc_next  = ID_W'(b[5:0]);
          id_left_next = 2'd1;
          phase_next   = PH_ID_MORE;
        end else if (b[7:5] == 3'b110) begin
          id_acc_next  = ID_W'(b[4:0]);
          id_left_next = 2'd2;
          phase_next   = PH_ID_MORE;
        end else if (b[7:4] == 4'b1110) begin
          id_acc_next  = ID_W'(b[3:0]);
          id_left_next = 2'd3;
          phase_next   = PH_ID_MORE;
        end else begin
          err_code_next = ST_BAD_PREFIX;
          phase_next    = PH_SKIP;
        end
      end
      PH_ID_MORE: begin
        id_acc_next  = {id_acc[ID_W-BYTE_W-1:0], b};
        id_left_next = id_left - 2'd1;
        if (id_left_next == '0) begin
          phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        decl_len_next = b;
        pay_left_next = b;
        phase_next    = (b == '0) ? PH_TRAIL : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pay_valid     = 1'b1;
        pay_left_next = pay_left - 8'd1;
        if (pay_left_next == '0) begin
          phase_next = PH_TRAIL;
        end
      end
      default: begin
        // trailing bytes, skip after an error, unused codes
      end
    endcase

    verdict_res                = '0;
    verdict_res.kind           = KIND_VERDICT;
    verdict_res.service_id     = id_acc_next;
    verdict_res.payload_length = decl_len_next;
    verdict_res.last           = 1'b1;
    if (err_code_next != ST_OK) begin
      verdict_res.status = err_code_next;
    end else if (phase_next == PH_TRAIL) begin
      verdict_res.status = ST_OK;
    end else begin
      verdict_res.status = ST_TRUNCATED;
    end

    if (frame_in.frame_end) begin
      verdict_valid = 1'b1;
      phase_next    = PH_VERSION;
      id_acc_next   = '0;
      id_left_next  = '0;
      decl_len_next = '0;
      pay_left_next = '0;
      err_code_next = ST_OK;
    end

    first_res = pay_valid ? pay_res : verdict_res;
    n_res     = PTR_W'({1'b0, pay_valid}) + PTR_W'({1'b0, verdict_valid});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_VERSION;
      id_acc   <= '0;
      id_left  <= '0;
      decl_len <= '0;
      pay_left <= '0;
      err_code <= ST_OK;
    end else if (in_fire) begin
      phase    <= phase_next;
      id_acc   <= id_acc_next;
      id_left  <= id_left_next;
      decl_len <= decl_len_next;
      pay_left <= pay_left_next;
      err_code <= err_code_next;
    end
  end

  // result queue, written with up to two entries per transfer
  always_ff @(posedge clk) begin
    if (in_fire && (n_res != '0)) begin
      q[wr_ptr] <= first_res;
    end
    if (in_fire && pay_valid && verdict_valid) begin
      q[wr_ptr + PTR_W'(1)] <= verdict_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + n_res;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (in_fire ? CNT_W'(n_res) : CNT_W'(0))
                     - CNT_W'(out_fire);
    end
  end

  assign result_out.valid          = (count != '0);
  assign result_out.kind           = q[rd_ptr].kind;
  assign result_out.data           = q[rd_ptr].data;
  assign result_out.service_id     = q[rd_ptr].service_id;
  assign result_out.payload_length = q[rd_ptr].payload_length;
  assign result_out.status         = q[rd_ptr].status;
  assign result_out.last           = q[rd_ptr].last;

endmodule
